### rtl/sfd_pkg.sv
// ============================================================================
// sfd_pkg: shared types and constants for the serial frame deframer
// Request layouts, parser phase codes and framing constants.
// ============================================================================
package sfd_pkg;

    localparam logic [7:0] START_BYTE     = 8'hE0;
    localparam logic [8:0] EXT_BASE       = 9'd255;
    localparam logic [2:0] PAYLOAD_NORMAL = 3'd3;
    localparam logic [2:0] PAYLOAD_EXT    = 3'd4;
    localparam logic [8:0] IDX_LEN1       = 9'd1;
    localparam logic [8:0] IDX_LEN2       = 9'd2;
    localparam logic [8:0] IDX_TYPE_EXT   = 9'd3;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN1 = 3'd1,
        PH_LEN2 = 3'd2,
        PH_TYPE = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       accepted;
        logic [8:0] byte_index;
        logic [7:0] frame_kind;
        logic [8:0] total_length;
        logic [2:0] payload_start;
        logic       frame_end;
        logic       aborted;
    } out_item_t;

endpackage

### rtl/sfd_parser.sv
// ============================================================================
// sfd_parser: frame parse state and per-byte result logic
// Holds the parse phase and frame context, and forms one result per byte.
// ============================================================================
module sfd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sfd_pkg::in_item_t  item,
    output sfd_pkg::out_item_t result
);
    import sfd_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [8:0] frame_len_reg;
    logic [8:0] frame_len_next;
    logic [8:0] next_index_reg;
    logic [8:0] next_index_next;
    logic [7:0] kind_reg;
    logic [7:0] kind_next;
    logic       extended_reg;
    logic       extended_next;

    logic [8:0] index_inc;
    logic       last_byte;
    logic       in_frame;
    logic       is_start;

    assign index_inc = next_index_reg + 9'd1;
    assign last_byte = (index_inc >= frame_len_reg);
    assign is_start  = (item.rx_byte == START_BYTE);
    assign in_frame  = (phase_reg == PH_LEN1) || (phase_reg == PH_LEN2) ||
                       (phase_reg == PH_TYPE) || (phase_reg == PH_DATA);

    always_comb
    begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        next_index_next = next_index_reg;
        kind_next       = kind_reg;
        extended_next   = extended_reg;
        if (item.line_error)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_LEN1:
                begin
                    frame_len_next  = {1'b0, item.rx_byte};
                    extended_next   = (item.rx_byte == 8'd0);
                    phase_next      = (item.rx_byte == 8'd0) ? PH_LEN2 : PH_TYPE;
                    next_index_next = IDX_LEN2;
                end
                PH_LEN2:
                begin
                    frame_len_next  = {1'b0, item.rx_byte} + EXT_BASE;
                    phase_next      = PH_TYPE;
                    next_index_next = IDX_TYPE_EXT;
                end
                PH_TYPE, PH_DATA:
                begin
                    if (phase_reg == PH_TYPE)
                    begin
                        kind_next = item.rx_byte;
                    end
                    next_index_next = index_inc;
                    phase_next      = last_byte ? PH_HUNT : PH_DATA;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (is_start)
                    begin
                        frame_len_next  = 9'd0;
                        kind_next       = 8'd0;
                        extended_next   = 1'b0;
                        next_index_next = IDX_LEN1;
                        phase_next      = PH_LEN1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result.data_byte  = item.rx_byte;
        result.accepted   = 1'b1;
        result.byte_index = 9'd0;
        result.frame_end  = 1'b0;
        result.aborted    = 1'b0;
        if (item.line_error)
        begin
            result.data_byte = 8'd0;
            result.accepted  = 1'b0;
            result.aborted   = in_frame;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_LEN1:          result.byte_index = IDX_LEN1;
                PH_LEN2:          result.byte_index = IDX_LEN2;
                PH_TYPE, PH_DATA:
                begin
                    result.byte_index = next_index_reg;
                    result.frame_end  = last_byte;
                end
                default:          result.accepted = is_start;
            endcase
        end
        result.frame_kind    = result.accepted ? kind_next : 8'd0;
        result.total_length  = result.accepted ? frame_len_next : 9'd0;
        result.payload_start = (result.accepted && extended_next) ? PAYLOAD_EXT
                                                                  : PAYLOAD_NORMAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            frame_len_reg  <= 9'd0;
            next_index_reg <= 9'd0;
            kind_reg       <= 8'd0;
            extended_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            next_index_reg <= next_index_next;
            kind_reg       <= kind_next;
            extended_reg   <= extended_next;
        end
    end

    property p_type_moves_on;
        @(posedge clk) disable iff (!rst_n)
        advance && !item.line_error && (phase_reg == PH_TYPE)
            |=> (phase_reg == PH_DATA) || (phase_reg == PH_HUNT);
    endproperty
    a_type_moves_on: assert property (p_type_moves_on)
        else $error("type byte did not lead to data or hunt");

    property p_error_hunts;
        @(posedge clk) disable iff (!rst_n)
        advance && item.line_error |=> (phase_reg == PH_HUNT);
    endproperty
    a_error_hunts: assert property (p_error_hunts)
        else $error("line error did not return to hunting");

    property p_zero_len_extends;
        @(posedge clk) disable iff (!rst_n)
        advance && !item.line_error && (phase_reg == PH_LEN1) && (item.rx_byte == 8'd0)
            |=> (phase_reg == PH_LEN2) && extended_reg;
    endproperty
    a_zero_len_extends: assert property (p_zero_len_extends)
        else $error("zero length byte did not select the extended header");

endmodule

### rtl/serial_frame_deframer.sv
// ============================================================================
// serial_frame_deframer: start-byte, length-prefixed frame deframer
// A request is registered in an input stage, then parsed into the result stage.
// Throughput: one request per cycle while result_stall is low; one result per request.
// The parse state is updated as a request moves into the result register.
// Reset: hunting for the start byte, both pipeline stages empty.
// ============================================================================
module serial_frame_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sfd_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output sfd_pkg::out_item_t result
);
    import sfd_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t parsed;
    logic      out_load;
    logic      advance;

    assign out_load     = !out_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_load;
    assign item_stall   = in_valid_reg && !out_load;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    sfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_item_reg <= parsed;
        end
    end

    property p_end_in_frame;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.frame_end |-> out_item_reg.accepted;
    endproperty
    a_end_in_frame: assert property (p_end_in_frame)
        else $error("frame end on a discarded byte");

    property p_abort_not_accepted;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.aborted
            |-> !out_item_reg.accepted && (out_item_reg.data_byte == 8'd0);
    endproperty
    a_abort_not_accepted: assert property (p_abort_not_accepted)
        else $error("abort result carries frame data");

    property p_start_at_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.accepted && (out_item_reg.byte_index == 9'd0)
            |-> (out_item_reg.data_byte == START_BYTE);
    endproperty
    a_start_at_zero: assert property (p_start_at_zero)
        else $error("frame position zero is not the start byte");

    property p_ext_needs_frame;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.payload_start == PAYLOAD_EXT)
            |-> out_item_reg.accepted;
    endproperty
    a_ext_needs_frame: assert property (p_ext_needs_frame)
        else $error("extended payload start outside a frame");

endmodule

### verif/tb_top.sv
// ============================================================================
// tb_top: testbench for the serial frame deframer
// A clocked driver presents received bytes and line errors from a queue that
// an initial block fills. A predictor tracks the frame parse and builds the
// expected echo for every accepted request. A clocked monitor compares each
// result with the oldest expected echo, field by field. Idling phases vary
// the gaps on both sides.
// ============================================================================
module tb_top;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 270;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        in_item_t   req;
        idle_mode_t mode;
        bit         hold;
    } pending_byte_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_stall;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    pending_byte_t byte_queue[$];
    out_item_t     echo_expected[$];
    pending_byte_t next_byte;
    out_item_t     want_echo;
    idle_mode_t    fill_mode = IDLE_NONE;
    idle_mode_t    rx_mode   = IDLE_NONE;
    bit            hold_next = 1'b0;
    int            bytes_queued = 0;
    int            bytes_taken  = 0;
    int            errors       = 0;
    int            cycles       = 0;

    phase_t     ph   = PH_HUNT;
    logic [8:0] flen = '0;
    logic [8:0] nidx = '0;
    logic [7:0] kind = '0;
    logic       ext  = 1'b0;

    serial_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic out_item_t deframe_byte(in_item_t req);
        out_item_t  r;
        logic [8:0] idx;
        logic       fin;
        r                = '0;
        idx              = '0;
        fin              = 1'b0;
        r.payload_start  = PAYLOAD_NORMAL;
        if (req.line_error)
        begin
            r.aborted = (ph != PH_HUNT);
            ph        = PH_HUNT;
            return r;
        end
        r.data_byte = req.rx_byte;
        case (ph)
            PH_LEN1:
            begin
                flen = {1'b0, req.rx_byte};
                ext  = (req.rx_byte == 8'd0);
                ph   = ext ? PH_LEN2 : PH_TYPE;
                idx  = IDX_LEN1;
                nidx = IDX_LEN2;
            end
            PH_LEN2:
            begin
                flen = {1'b0, req.rx_byte} + EXT_BASE;
                ph   = PH_TYPE;
                idx  = IDX_LEN2;
                nidx = IDX_TYPE_EXT;
            end
            PH_TYPE, PH_DATA:
            begin
                if (ph == PH_TYPE)
                    kind = req.rx_byte;
                idx  = nidx;
                nidx = nidx + 9'd1;
                if (nidx >= flen)
                begin
                    fin = 1'b1;
                    ph  = PH_HUNT;
                end
                else
                    ph = PH_DATA;
            end
            default:
            begin
                if (req.rx_byte != START_BYTE)
                    return r;
                flen = '0;
                kind = '0;
                ext  = 1'b0;
                nidx = 9'd1;
                ph   = PH_LEN1;
                idx  = '0;
            end
        endcase
        r.accepted      = 1'b1;
        r.byte_index    = idx;
        r.frame_kind    = kind;
        r.total_length  = flen;
        r.payload_start = ext ? PAYLOAD_EXT : PAYLOAD_NORMAL;
        r.frame_end     = fin;
        return r;
    endfunction

    function automatic int send_idle_pct(idle_mode_t m);
        case (m)
            IDLE_SEND: return 69;
            IDLE_BOTH: return 29;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(idle_mode_t m);
        case (m)
            IDLE_RECV: return 69;
            IDLE_BOTH: return 29;
            default:   return 0;
        endcase
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endfunction

    // drive requests and predict their echoes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
            begin
                echo_expected.push_back(deframe_byte(item));
                bytes_taken++;
            end
            if (!item_valid || !item_stall)
            begin
                if (byte_queue.size() != 0
                    && !(byte_queue[0].hold && echo_expected.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct(byte_queue[0].mode))
                begin
                    next_byte  = byte_queue.pop_front();
                    rx_mode    = next_byte.mode;
                    item       <= next_byte.req;
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // check results against the oldest expected echo
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (echo_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %p", $time, result);
                    errors++;
                end
                else
                begin
                    want_echo = echo_expected.pop_front();
                    check_field("data_byte", want_echo.data_byte, result.data_byte);
                    check_field("accepted", want_echo.accepted, result.accepted);
                    check_field("byte_index", want_echo.byte_index, result.byte_index);
                    check_field("frame_kind", want_echo.frame_kind, result.frame_kind);
                    check_field("total_length", want_echo.total_length,
                                result.total_length);
                    check_field("payload_start", want_echo.payload_start,
                                result.payload_start);
                    check_field("frame_end", want_echo.frame_end, result.frame_end);
                    check_field("aborted", want_echo.aborted, result.aborted);
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct(rx_mode));
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] b, logic err);
        pending_byte_t p;
        p.req.rx_byte    = b;
        p.req.line_error = err;
        p.mode           = fill_mode;
        p.hold           = hold_next;
        hold_next        = 1'b0;
        byte_queue.push_back(p);
        bytes_queued++;
    endtask

    // cut < 0 (or past the frame) sends the whole frame, else drop the line after cut bytes
    task automatic add_frame(logic [7:0] len_byte, logic [7:0] ext_byte, int cut);
        int         total;
        int         count;
        logic [7:0] b;
        total = (len_byte == 8'd0) ? int'(ext_byte) + 255 : int'(len_byte);
        count = (total < 3) ? 3 : total;
        for (int i = 0; i < count; i++)
        begin
            if (i == cut)
            begin
                add_byte(8'($urandom_range(0, 255)), 1'b1);
                return;
            end
            if (i == 0)
                b = START_BYTE;
            else if (i == 1)
                b = len_byte;
            else if (i == 2 && len_byte == 8'd0)
                b = ext_byte;
            else
                b = 8'($urandom_range(0, 255));
            add_byte(b, 1'b0);
        end
    endtask

    initial
    begin
        int         phase_start;
        int         pick;
        int         sel;
        logic [7:0] noise;

        add_byte(8'hA5, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h7E, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h04, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h5A, 1'b1);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h05, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(START_BYTE, 1'b0);
        add_byte(8'hFF, 1'b1);

        for (int m = 0; m < 4; m++)
        begin
            fill_mode   = idle_mode_t'(m);
            hold_next   = 1'b1;
            phase_start = bytes_queued;
            if (m == 1)
                add_frame(8'd0, 8'd0, -1);
            if (m == 3)
                add_frame(8'd0, 8'd255, -1);
            while (bytes_queued - phase_start < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        noise = 8'($urandom_range(0, 255));
                        if (noise == START_BYTE)
                            noise = ~noise;
                        add_byte(noise, 1'b0);
                    end
                end
                else if (pick < 14)
                    add_byte(8'($urandom_range(0, 255)), 1'b1);
                else if (pick < 30)
                    add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              $urandom_range(1, 10));
                else
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 7)
                        add_frame(8'($urandom_range(1, 12)), 8'd0, -1);
                    else if (sel < 9)
                        add_frame(8'($urandom_range(13, 64)), 8'd0, -1);
                    else
                        add_frame(8'($urandom_range(65, 255)), 8'd0, -1);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_taken == bytes_queued);
        wait (echo_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/sfd_pkg.sv
rtl/sfd_parser.sv
rtl/serial_frame_deframer.sv
verif/tb_top.sv
